// ===== hw/rtl/gmpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpd_pkg
// Shared widths, register indexes, reset values and types of the deframer.
// ----------------------------------------------------------------------------
package gmpd_pkg;

  // field widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ModeW     = 5;
  localparam int unsigned PayLenW   = 16;
  localparam int unsigned KindW     = 2;
  localparam int unsigned EventW    = 4;
  localparam int unsigned CountOutW = 17;

  // register widths
  localparam int unsigned UbxMaxW   = 17;
  localparam int unsigned NmeaMaxW  = 11;
  localparam int unsigned UnidMaxW  = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 17;

  // default counter width, range 11 to 17
  localparam int unsigned CountBitsDef = 17;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_IDX_MAX_UBX  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MAX_NMEA = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_MAX_UNID = 2'd2;

  // register reset values
  localparam logic [UbxMaxW-1:0]  MAX_UBX_RST  = 17'd2048;
  localparam logic [NmeaMaxW-1:0] MAX_NMEA_RST = 11'd256;
  localparam logic [UnidMaxW-1:0] MAX_UNID_RST = 16'd256;

  // frame kinds
  localparam logic [KindW-1:0] KIND_UNID = 2'd0;
  localparam logic [KindW-1:0] KIND_NMEA = 2'd1;
  localparam logic [KindW-1:0] KIND_UBX  = 2'd2;
  localparam logic [KindW-1:0] KIND_RTCM = 2'd3;

  // verdict events
  localparam logic [EventW-1:0] EV_NONE      = 4'd0;
  localparam logic [EventW-1:0] EV_CHUNK_END = 4'd1;
  localparam logic [EventW-1:0] EV_NMEA_OK   = 4'd2;
  localparam logic [EventW-1:0] EV_NMEA_LONG = 4'd3;
  localparam logic [EventW-1:0] EV_NMEA_NOLF = 4'd4;
  localparam logic [EventW-1:0] EV_UBX_SYNC  = 4'd5;
  localparam logic [EventW-1:0] EV_UBX_LEN   = 4'd6;
  localparam logic [EventW-1:0] EV_UBX_CK    = 4'd7;
  localparam logic [EventW-1:0] EV_UBX_OK    = 4'd8;
  localparam logic [EventW-1:0] EV_RTCM_DONE = 4'd9;
  localparam logic [EventW-1:0] EV_FLUSH     = 4'd10;

  // parser state apart from the byte counter
  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [PayLenW-1:0] payload_len;
    logic [ByteW-1:0]   fletcher_a;
    logic [ByteW-1:0]   fletcher_b;
    logic [ByteW-1:0]   received_ck_a;
  } parse_state_t;

  // per-byte result apart from the count
  typedef struct packed {
    logic [ByteW-1:0]  byte_out;
    logic              byte_valid;
    logic [KindW-1:0]  frame_kind;
    logic              frame_start;
    logic [EventW-1:0] event_res;
  } byte_res_t;

  // live configuration
  typedef struct packed {
    logic [UbxMaxW-1:0]  max_ubx_frame_len;
    logic [NmeaMaxW-1:0] max_nmea_len;
    logic [UnidMaxW-1:0] max_unidentified_len;
  } cfg_t;

endpackage

// ===== hw/rtl/gnss_multi_protocol_deframer.sv =====
`timescale 1ns / 1ps
// The result beat of an accepted input beat is registered and offered in the cycle after.
// Throughput: one beat per cycle; the parser state and the result register
// both load on the accepting edge, so the only back-pressure is a full
// result register that is not being drained.
// Reset: parser hunts for a start byte, counters and checksums clear, the
// registers return to their defaults and no result is held.
// ----------------------------------------------------------------------------
// gnss_multi_protocol_deframer
// Splits a receiver byte stream into NMEA, UBX and RTCM3 frames per byte.
// ----------------------------------------------------------------------------
module gnss_multi_protocol_deframer #(
  parameter int unsigned COUNT_BITS = gmpd_pkg::CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] action
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] byte_out, [8] byte_valid, [9] frame_start, [13:10] event_res,
  // [30:14] buffered_count, [31] zero
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] frame_kind
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  gmpd_pkg::cfg_t         cfg_q;
  gmpd_pkg::parse_state_t state_q;
  gmpd_pkg::parse_state_t state_d;
  logic [COUNT_BITS-1:0]  count_q;
  logic [COUNT_BITS-1:0]  count_d;
  gmpd_pkg::byte_res_t    res_d;
  gmpd_pkg::byte_res_t    res_q;
  logic [16:0]            out_count_q;
  logic                   out_valid_q;
  logic                   in_beat;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_ubx_frame_len    <= gmpd_pkg::MAX_UBX_RST;
      cfg_q.max_nmea_len         <= gmpd_pkg::MAX_NMEA_RST;
      cfg_q.max_unidentified_len <= gmpd_pkg::MAX_UNID_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gmpd_pkg::CFG_IDX_MAX_UBX:  cfg_q.max_ubx_frame_len <= cfg_data_i;
        gmpd_pkg::CFG_IDX_MAX_NMEA: cfg_q.max_nmea_len <= cfg_data_i[10:0];
        gmpd_pkg::CFG_IDX_MAX_UNID: cfg_q.max_unidentified_len <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // take a beat when the result register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  gmpd_step #(
    .COUNT_BITS (COUNT_BITS)
  ) u_step (
    .state_i     (state_q),
    .count_i     (count_q),
    .cfg_i       (cfg_q),
    .action_i    (s_axis_tuser[0]),
    .data_byte_i (s_axis_tdata),
    .state_o     (state_d),
    .count_o     (count_d),
    .res_o       (res_d)
  );

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      count_q <= '0;
    end else if (in_beat) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      res_q       <= res_d;
      out_count_q <= 17'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_count_q, res_q.event_res, res_q.frame_start,
                          res_q.byte_valid, res_q.byte_out};
  assign m_axis_tuser  = res_q.frame_kind;

endmodule

// ===== hw/rtl/gmpd_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmpd_step
// Next-state and result logic of the deframer for one byte or flush.
// ----------------------------------------------------------------------------
module gmpd_step #(
  parameter int unsigned COUNT_BITS = gmpd_pkg::CountBitsDef
) (
  input  gmpd_pkg::parse_state_t       state_i,
  input  logic [COUNT_BITS-1:0]        count_i,
  input  gmpd_pkg::cfg_t               cfg_i,
  input  logic                         action_i,
  input  logic [gmpd_pkg::ByteW-1:0]   data_byte_i,
  output gmpd_pkg::parse_state_t       state_o,
  output logic [COUNT_BITS-1:0]        count_o,
  output gmpd_pkg::byte_res_t          res_o
);

  // parser modes
  localparam logic [4:0] MODE_HUNT         = 5'd0;
  localparam logic [4:0] MODE_UBX_SYNC2    = 5'd1;
  localparam logic [4:0] MODE_UBX_CLASS    = 5'd2;
  localparam logic [4:0] MODE_UBX_ID       = 5'd3;
  localparam logic [4:0] MODE_UBX_LEN1     = 5'd4;
  localparam logic [4:0] MODE_UBX_LEN2     = 5'd5;
  localparam logic [4:0] MODE_UBX_PAYLOAD  = 5'd6;
  localparam logic [4:0] MODE_UBX_CKA      = 5'd7;
  localparam logic [4:0] MODE_UBX_CKB      = 5'd8;
  localparam logic [4:0] MODE_NMEA_CR      = 5'd9;
  localparam logic [4:0] MODE_NMEA_LF      = 5'd10;
  localparam logic [4:0] MODE_RTCM_LEN1    = 5'd11;
  localparam logic [4:0] MODE_RTCM_LEN2    = 5'd12;
  localparam logic [4:0] MODE_RTCM_PAYLOAD = 5'd13;
  localparam logic [4:0] MODE_RTCM_CRC1    = 5'd14;
  localparam logic [4:0] MODE_RTCM_CRC2    = 5'd15;
  localparam logic [4:0] MODE_RTCM_CRC3    = 5'd16;

  // stream characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SYNC1  = 8'hB5;
  localparam logic [7:0] CH_SYNC2  = 8'h62;
  localparam logic [7:0] CH_RTCM   = 8'hD3;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  logic [COUNT_BITS-1:0]         cnt_inc;
  logic [16:0]                   cnt_ext;
  logic [16:0]                   cnt_inc_ext;
  logic [7:0]                    fa_sum;
  logic [7:0]                    fb_sum;
  logic [16:0]                   ubx_lim;
  logic [10:0]                   nmea_lim;
  logic [15:0]                   ubx_len;
  logic [15:0]                   rtcm_len;
  logic [15:0]                   pay_dec;
  logic                          ck_match;

  // saturating count and running checksum
  assign cnt_inc     = (count_i == CountMax) ? CountMax : count_i + CountOne;
  assign cnt_ext     = 17'(count_i);
  assign cnt_inc_ext = 17'(cnt_inc);
  assign fa_sum      = state_i.fletcher_a + data_byte_i;
  assign fb_sum      = state_i.fletcher_b + fa_sum;
  assign ck_match    = (state_i.received_ck_a == state_i.fletcher_a) &&
                       (data_byte_i == state_i.fletcher_b);

  // limits derived from the registers, saturating at zero
  assign ubx_lim  = (cfg_i.max_ubx_frame_len >= 17'd8) ?
                    cfg_i.max_ubx_frame_len - 17'd8 : 17'd0;
  assign nmea_lim = (cfg_i.max_nmea_len >= 11'd1) ? cfg_i.max_nmea_len - 11'd1 : 11'd0;

  // length assembly
  assign ubx_len  = {data_byte_i, state_i.payload_len[7:0]};
  assign rtcm_len = {6'd0, state_i.payload_len[1:0], data_byte_i};
  assign pay_dec  = state_i.payload_len - 16'd1;

  always_comb begin
    state_o           = state_i;
    count_o           = count_i;
    res_o.byte_out    = data_byte_i;
    res_o.byte_valid  = 1'b1;
    res_o.frame_kind  = gmpd_pkg::KIND_UNID;
    res_o.frame_start = 1'b0;
    res_o.event_res   = gmpd_pkg::EV_NONE;

    if (action_i) begin
      // flush drops everything in progress
      state_o          = '0;
      state_o.mode     = MODE_HUNT;
      count_o          = '0;
      res_o.byte_out   = '0;
      res_o.byte_valid = 1'b0;
      res_o.event_res  = gmpd_pkg::EV_FLUSH;
    end else begin
      unique case (state_i.mode) inside
        MODE_HUNT: begin
          if (data_byte_i == CH_DOLLAR || data_byte_i == CH_SYNC1 ||
              data_byte_i == CH_RTCM) begin
            if (count_i != '0) res_o.event_res = gmpd_pkg::EV_CHUNK_END;
            count_o           = CountOne;
            res_o.frame_start = 1'b1;
            if (data_byte_i == CH_DOLLAR) begin
              res_o.frame_kind = gmpd_pkg::KIND_NMEA;
              state_o.mode     = MODE_NMEA_CR;
            end else if (data_byte_i == CH_SYNC1) begin
              res_o.frame_kind   = gmpd_pkg::KIND_UBX;
              state_o.mode       = MODE_UBX_SYNC2;
              state_o.fletcher_a = '0;
              state_o.fletcher_b = '0;
            end else begin
              res_o.frame_kind = gmpd_pkg::KIND_RTCM;
              state_o.mode     = MODE_RTCM_LEN1;
            end
          end else if (cnt_ext >= 17'(cfg_i.max_unidentified_len)) begin
            res_o.event_res = gmpd_pkg::EV_CHUNK_END;
            count_o         = CountOne;
          end else begin
            count_o = cnt_inc;
          end
        end
        MODE_UBX_SYNC2: begin
          res_o.frame_kind = gmpd_pkg::KIND_UBX;
          if (data_byte_i == CH_SYNC2) begin
            count_o      = cnt_inc;
            state_o.mode = MODE_UBX_CLASS;
          end else begin
            res_o.byte_valid = 1'b0;
            res_o.event_res  = gmpd_pkg::EV_UBX_SYNC;
            state_o.mode     = MODE_HUNT;
            count_o          = '0;
          end
        end
        MODE_UBX_CLASS, MODE_UBX_ID, MODE_UBX_LEN1: begin
          res_o.frame_kind   = gmpd_pkg::KIND_UBX;
          count_o            = cnt_inc;
          state_o.fletcher_a = fa_sum;
          state_o.fletcher_b = fb_sum;
          if (state_i.mode == MODE_UBX_LEN1) begin
            state_o.payload_len = 16'(data_byte_i);
            state_o.mode        = MODE_UBX_LEN2;
          end else if (state_i.mode == MODE_UBX_ID) begin
            state_o.mode = MODE_UBX_LEN1;
          end else begin
            state_o.mode = MODE_UBX_ID;
          end
        end
        MODE_UBX_LEN2: begin
          res_o.frame_kind    = gmpd_pkg::KIND_UBX;
          count_o             = cnt_inc;
          state_o.fletcher_a  = fa_sum;
          state_o.fletcher_b  = fb_sum;
          state_o.payload_len = ubx_len;
          if (17'(ubx_len) > ubx_lim) begin
            res_o.event_res = gmpd_pkg::EV_UBX_LEN;
            state_o.mode    = MODE_HUNT;
            count_o         = '0;
          end else begin
            state_o.mode = (ubx_len != '0) ? MODE_UBX_PAYLOAD : MODE_UBX_CKA;
          end
        end
        MODE_UBX_PAYLOAD: begin
          res_o.frame_kind    = gmpd_pkg::KIND_UBX;
          count_o             = cnt_inc;
          state_o.fletcher_a  = fa_sum;
          state_o.fletcher_b  = fb_sum;
          state_o.payload_len = pay_dec;
          if (pay_dec == '0) state_o.mode = MODE_UBX_CKA;
        end
        MODE_UBX_CKA: begin
          res_o.frame_kind      = gmpd_pkg::KIND_UBX;
          count_o               = cnt_inc;
          state_o.received_ck_a = data_byte_i;
          state_o.mode          = MODE_UBX_CKB;
        end
        MODE_UBX_CKB: begin
          res_o.frame_kind = gmpd_pkg::KIND_UBX;
          res_o.event_res  = ck_match ? gmpd_pkg::EV_UBX_OK : gmpd_pkg::EV_UBX_CK;
          state_o.mode     = MODE_HUNT;
          count_o          = '0;
        end
        MODE_NMEA_CR: begin
          res_o.frame_kind = gmpd_pkg::KIND_NMEA;
          count_o          = cnt_inc;
          if (cnt_inc_ext >= 17'(nmea_lim)) begin
            res_o.event_res = gmpd_pkg::EV_NMEA_LONG;
            state_o.mode    = MODE_HUNT;
            count_o         = '0;
          end else if (data_byte_i == CH_CR) begin
            state_o.mode = MODE_NMEA_LF;
          end
        end
        MODE_NMEA_LF: begin
          res_o.frame_kind = gmpd_pkg::KIND_NMEA;
          res_o.event_res  = (data_byte_i == CH_LF) ? gmpd_pkg::EV_NMEA_OK
                                                    : gmpd_pkg::EV_NMEA_NOLF;
          state_o.mode     = MODE_HUNT;
          count_o          = '0;
        end
        MODE_RTCM_LEN1: begin
          res_o.frame_kind    = gmpd_pkg::KIND_RTCM;
          count_o             = cnt_inc;
          state_o.payload_len = 16'(data_byte_i);
          state_o.mode        = MODE_RTCM_LEN2;
        end
        MODE_RTCM_LEN2: begin
          res_o.frame_kind    = gmpd_pkg::KIND_RTCM;
          count_o             = cnt_inc;
          state_o.payload_len = rtcm_len;
          state_o.mode        = (rtcm_len != '0) ? MODE_RTCM_PAYLOAD : MODE_RTCM_CRC1;
        end
        MODE_RTCM_PAYLOAD: begin
          res_o.frame_kind    = gmpd_pkg::KIND_RTCM;
          count_o             = cnt_inc;
          state_o.payload_len = pay_dec;
          if (pay_dec == '0) state_o.mode = MODE_RTCM_CRC1;
        end
        MODE_RTCM_CRC1, MODE_RTCM_CRC2: begin
          res_o.frame_kind = gmpd_pkg::KIND_RTCM;
          count_o          = cnt_inc;
          state_o.mode     = (state_i.mode == MODE_RTCM_CRC1) ? MODE_RTCM_CRC2
                                                              : MODE_RTCM_CRC3;
        end
        MODE_RTCM_CRC3: begin
          res_o.frame_kind = gmpd_pkg::KIND_RTCM;
          res_o.event_res  = gmpd_pkg::EV_RTCM_DONE;
          state_o.mode     = MODE_HUNT;
          count_o          = '0;
        end
        default: begin
          state_o.mode = MODE_HUNT;
          count_o      = '0;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_gnss_multi_protocol_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gnss_multi_protocol_deframer
// Streams NMEA, UBX and RTCM3 traffic, noise and flushes into the deframer
// under several register settings. A cycle-free predictor tracks the parser
// and every output beat is compared field by field in order, with random
// gaps and stalls on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_gnss_multi_protocol_deframer;

  // stream codes and framing characters
  localparam logic        ACT_DATA   = 1'b0;
  localparam logic        ACT_FLUSH  = 1'b1;
  localparam logic [7:0]  CH_DOLLAR  = 8'h24;
  localparam logic [7:0]  SYNC_UBX1  = 8'hB5;
  localparam logic [7:0]  SYNC_UBX2  = 8'h62;
  localparam logic [7:0]  SYNC_RTCM  = 8'hD3;
  localparam logic [7:0]  CH_CR      = 8'd13;
  localparam logic [7:0]  CH_LF      = 8'd10;
  localparam logic [gmpd_pkg::CfgIdxW-1:0] CFG_IDX_UNUSED = 2'd3;

  localparam int unsigned COUNT_SAT      = (1 << gmpd_pkg::CountBitsDef) - 1;
  localparam int unsigned PHASE_BEATS    = 165;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned MAX_GAP        = 17;
  // idle enables per phase, bit n for phase n (phase 0 is the directed part)
  localparam logic [6:0] SRC_IDLE_MASK = 7'b1101010;
  localparam logic [6:0] SNK_IDLE_MASK = 7'b1011100;

  typedef enum logic [4:0] {
    PM_HUNT, PM_UBX_SYNC2, PM_UBX_CLASS, PM_UBX_ID, PM_UBX_LEN1, PM_UBX_LEN2,
    PM_UBX_PAYLOAD, PM_UBX_CKA, PM_UBX_CKB, PM_NMEA_CR, PM_NMEA_LF,
    PM_RTCM_LEN1, PM_RTCM_LEN2, PM_RTCM_PAYLOAD, PM_RTCM_CRC1, PM_RTCM_CRC2,
    PM_RTCM_CRC3
  } parse_mode_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data;
  } stream_beat_t;

  typedef struct packed {
    logic [7:0]                     byte_out;
    logic                           byte_valid;
    logic [gmpd_pkg::KindW-1:0]     kind;
    logic                           start;
    logic [gmpd_pkg::EventW-1:0]    ev;
    logic [gmpd_pkg::CountOutW-1:0] count;
  } byte_verdict_t;

  // dut signals
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  // predicted parser state and live registers
  parse_mode_e                   rx_mode = PM_HUNT;
  int unsigned                   held_bytes = 0;
  logic [15:0]                   remaining_len = '0;
  logic [7:0]                    ck_sum_a = '0;
  logic [7:0]                    ck_sum_b = '0;
  logic [7:0]                    got_ck_a = '0;
  logic [gmpd_pkg::UbxMaxW-1:0]  lim_ubx_frame = gmpd_pkg::MAX_UBX_RST;
  logic [gmpd_pkg::NmeaMaxW-1:0] lim_nmea = gmpd_pkg::MAX_NMEA_RST;
  logic [gmpd_pkg::UnidMaxW-1:0] lim_unid = gmpd_pkg::MAX_UNID_RST;

  // traffic bookkeeping
  stream_beat_t  beats_to_send[$];
  byte_verdict_t verdicts_due[$];
  int unsigned   n_queued = 0;
  int unsigned   n_sent = 0;
  int unsigned   n_flushes = 0;
  int unsigned   n_settings = 0;
  int unsigned   n_fail = 0;
  int unsigned   n_frames_ok = 0;
  int unsigned   n_frame_errs = 0;
  int unsigned   n_chunks = 0;
  int unsigned   holds_asked = 0;
  int unsigned   holds_served = 0;
  bit            src_idle_en = 1'b0;
  bit            snk_idle_en = 1'b0;

  gnss_multi_protocol_deframer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void hunt_again();
    rx_mode = PM_HUNT;
    held_bytes = 0;
  endfunction

  function automatic void bump_count();
    held_bytes = (held_bytes >= COUNT_SAT) ? COUNT_SAT : held_bytes + 1;
  endfunction

  function automatic void fletcher_in(input logic [7:0] b);
    ck_sum_a = ck_sum_a + b;
    ck_sum_b = ck_sum_b + ck_sum_a;
  endfunction

  // parser step for one accepted beat
  function automatic byte_verdict_t predict_verdict(input logic act, input logic [7:0] din);
    byte_verdict_t v;
    int unsigned   lim;
    v.byte_out   = din;
    v.byte_valid = 1'b1;
    v.kind       = gmpd_pkg::KIND_UNID;
    v.start      = 1'b0;
    v.ev         = gmpd_pkg::EV_NONE;
    if (act == ACT_FLUSH) begin
      hunt_again();
      remaining_len = '0;
      ck_sum_a      = '0;
      ck_sum_b      = '0;
      got_ck_a      = '0;
      v.byte_out    = '0;
      v.byte_valid  = 1'b0;
      v.ev          = gmpd_pkg::EV_FLUSH;
    end else begin
      case (rx_mode) inside
        PM_HUNT: begin
          if (din == CH_DOLLAR || din == SYNC_UBX1 || din == SYNC_RTCM) begin
            // start char closes any open chunk
            if (held_bytes != 0) v.ev = gmpd_pkg::EV_CHUNK_END;
            held_bytes = 1;
            v.start = 1'b1;
            if (din == CH_DOLLAR) begin
              v.kind = gmpd_pkg::KIND_NMEA;
              rx_mode = PM_NMEA_CR;
            end else if (din == SYNC_UBX1) begin
              v.kind = gmpd_pkg::KIND_UBX;
              rx_mode = PM_UBX_SYNC2;
              ck_sum_a = '0;
              ck_sum_b = '0;
            end else begin
              v.kind = gmpd_pkg::KIND_RTCM;
              rx_mode = PM_RTCM_LEN1;
            end
          end else if (held_bytes >= lim_unid) begin
            v.ev = gmpd_pkg::EV_CHUNK_END;
            held_bytes = 1;
          end else begin
            bump_count();
          end
        end
        PM_UBX_SYNC2: begin
          v.kind = gmpd_pkg::KIND_UBX;
          if (din == SYNC_UBX2) begin
            bump_count();
            rx_mode = PM_UBX_CLASS;
          end else begin
            // dropped, not rescanned as a start char
            v.byte_valid = 1'b0;
            v.ev = gmpd_pkg::EV_UBX_SYNC;
            hunt_again();
          end
        end
        PM_UBX_CLASS, PM_UBX_ID, PM_UBX_LEN1: begin
          v.kind = gmpd_pkg::KIND_UBX;
          bump_count();
          fletcher_in(din);
          if (rx_mode == PM_UBX_CLASS) begin
            rx_mode = PM_UBX_ID;
          end else if (rx_mode == PM_UBX_ID) begin
            rx_mode = PM_UBX_LEN1;
          end else begin
            remaining_len = {8'h00, din};
            rx_mode = PM_UBX_LEN2;
          end
        end
        PM_UBX_LEN2: begin
          lim = (lim_ubx_frame >= 8) ? lim_ubx_frame - 8 : 0;
          v.kind = gmpd_pkg::KIND_UBX;
          bump_count();
          fletcher_in(din);
          remaining_len = {din, remaining_len[7:0]};
          if (remaining_len > lim) begin
            v.ev = gmpd_pkg::EV_UBX_LEN;
            hunt_again();
          end else if (remaining_len != 0) begin
            rx_mode = PM_UBX_PAYLOAD;
          end else begin
            rx_mode = PM_UBX_CKA;
          end
        end
        PM_UBX_PAYLOAD: begin
          v.kind = gmpd_pkg::KIND_UBX;
          bump_count();
          fletcher_in(din);
          remaining_len = remaining_len - 16'd1;
          if (remaining_len == 0) rx_mode = PM_UBX_CKA;
        end
        PM_UBX_CKA: begin
          v.kind = gmpd_pkg::KIND_UBX;
          bump_count();
          got_ck_a = din;
          rx_mode = PM_UBX_CKB;
        end
        PM_UBX_CKB: begin
          v.kind = gmpd_pkg::KIND_UBX;
          v.ev = (got_ck_a == ck_sum_a && din == ck_sum_b) ? gmpd_pkg::EV_UBX_OK
                                                          : gmpd_pkg::EV_UBX_CK;
          hunt_again();
        end
        PM_NMEA_CR: begin
          lim = (lim_nmea >= 1) ? lim_nmea - 1 : 0;
          v.kind = gmpd_pkg::KIND_NMEA;
          bump_count();
          if (held_bytes >= lim) begin
            v.ev = gmpd_pkg::EV_NMEA_LONG;
            hunt_again();
          end else if (din == CH_CR) begin
            rx_mode = PM_NMEA_LF;
          end
        end
        PM_NMEA_LF: begin
          v.kind = gmpd_pkg::KIND_NMEA;
          v.ev = (din == CH_LF) ? gmpd_pkg::EV_NMEA_OK : gmpd_pkg::EV_NMEA_NOLF;
          hunt_again();
        end
        PM_RTCM_LEN1: begin
          v.kind = gmpd_pkg::KIND_RTCM;
          bump_count();
          remaining_len = {8'h00, din};
          rx_mode = PM_RTCM_LEN2;
        end
        PM_RTCM_LEN2: begin
          v.kind = gmpd_pkg::KIND_RTCM;
          bump_count();
          // ten-bit length, reserved bits dropped
          remaining_len = {6'd0, remaining_len[1:0], din};
          if (remaining_len != 0) rx_mode = PM_RTCM_PAYLOAD;
          else rx_mode = PM_RTCM_CRC1;
        end
        PM_RTCM_PAYLOAD: begin
          v.kind = gmpd_pkg::KIND_RTCM;
          bump_count();
          remaining_len = remaining_len - 16'd1;
          if (remaining_len == 0) rx_mode = PM_RTCM_CRC1;
        end
        PM_RTCM_CRC1: begin
          v.kind = gmpd_pkg::KIND_RTCM;
          bump_count();
          rx_mode = PM_RTCM_CRC2;
        end
        PM_RTCM_CRC2: begin
          v.kind = gmpd_pkg::KIND_RTCM;
          bump_count();
          rx_mode = PM_RTCM_CRC3;
        end
        PM_RTCM_CRC3: begin
          v.kind = gmpd_pkg::KIND_RTCM;
          v.ev = gmpd_pkg::EV_RTCM_DONE;
          hunt_again();
        end
        default: begin
          hunt_again();
        end
      endcase
    end
    v.count = held_bytes[gmpd_pkg::CountOutW-1:0];
    return v;
  endfunction

  // ------------------------------------------------------------------- driver

  always @(posedge clk_i) begin : drive
    stream_beat_t nxt;
    int unsigned  send_gap;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        verdicts_due.push_back(predict_verdict(s_axis_tuser[0], s_axis_tdata));
        n_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          nxt = beats_to_send.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.data;
          s_axis_tuser  <= nxt.action;
          send_gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // compares each output beat and paces tready
  always @(posedge clk_i) begin : monitor
    byte_verdict_t want;
    bit            took;
    int unsigned   nstall;
    int unsigned   sink_stall;
    int unsigned   hold_left;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
      hold_left = 0;
    end else begin
      took = m_axis_tvalid && m_axis_tready;
      if (took) begin
        if (verdicts_due.size() == 0) begin
          $error("output beat with nothing expected: tdata %h tuser %0d",
                 m_axis_tdata, m_axis_tuser);
          n_fail++;
        end else begin
          want = verdicts_due.pop_front();
          check_field("byte_out", want.byte_out, m_axis_tdata[7:0]);
          check_field("byte_valid", want.byte_valid, m_axis_tdata[8]);
          check_field("frame_start", want.start, m_axis_tdata[9]);
          check_field("event_res", want.ev, m_axis_tdata[13:10]);
          check_field("buffered_count", want.count, m_axis_tdata[30:14]);
          check_field("frame_kind", want.kind, m_axis_tuser);
          case (want.ev) inside
            gmpd_pkg::EV_NMEA_OK, gmpd_pkg::EV_UBX_OK, gmpd_pkg::EV_RTCM_DONE:
              n_frames_ok++;
            gmpd_pkg::EV_NMEA_LONG, gmpd_pkg::EV_NMEA_NOLF, gmpd_pkg::EV_UBX_SYNC,
            gmpd_pkg::EV_UBX_LEN, gmpd_pkg::EV_UBX_CK:
              n_frame_errs++;
            gmpd_pkg::EV_CHUNK_END: n_chunks++;
            default: ;
          endcase
        end
      end
      // long hold-off first, then the per-beat stall
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        nstall = took ? (snk_idle_en ? $urandom_range(0, MAX_GAP) : 0) : sink_stall;
        if (nstall != 0) begin
          sink_stall = nstall - 1;
          m_axis_tready <= 1'b0;
        end else begin
          sink_stall = 0;
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, verdicts_due.size());
        $display("** gnss_multi_protocol_deframer: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic put_beat(input logic act, input logic [7:0] b);
    stream_beat_t it;
    it.action = act;
    it.data   = b;
    beats_to_send.push_back(it);
    n_queued++;
  endtask

  task automatic put_flush();
    put_beat(ACT_FLUSH, 8'($urandom));
    n_flushes++;
  endtask

  task automatic put_summed(input logic [7:0] b, inout logic [7:0] sa, inout logic [7:0] sb);
    put_beat(ACT_DATA, b);
    sa = sa + b;
    sb = sb + sa;
  endtask

  // unidentified bytes, keeping clear of '$' and the rtcm preamble
  task automatic queue_noise();
    logic [7:0]  c;
    int unsigned n;
    n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
    repeat (n) begin
      c = 8'($urandom);
      if (c == CH_DOLLAR || c == SYNC_RTCM) c = c ^ 8'h01;
      put_beat(ACT_DATA, c);
    end
  endtask

  task automatic queue_nmea();
    logic [7:0]  c;
    int unsigned n;
    int unsigned r;
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 14) : $urandom_range(15, 70);
    put_beat(ACT_DATA, CH_DOLLAR);
    repeat (n) begin
      c = 8'($urandom);
      if (c == CH_CR) c = 8'h2A;
      put_beat(ACT_DATA, c);
    end
    r = $urandom_range(0, 99);
    if (r < 80) begin
      put_beat(ACT_DATA, CH_CR);
      put_beat(ACT_DATA, CH_LF);
    end else if (r < 90) begin
      c = 8'($urandom);
      if (c == CH_LF) c = 8'h00;
      put_beat(ACT_DATA, CH_CR);
      put_beat(ACT_DATA, c);
    end else begin
      put_flush();
    end
  endtask

  task automatic queue_ubx();
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  bad;
    logic [15:0] len;
    int unsigned lim;
    int unsigned r;
    int unsigned plen;
    int unsigned cut;
    bit          len_err;
    lim = (lim_ubx_frame >= 8) ? lim_ubx_frame - 8 : 0;
    r = $urandom_range(0, 99);
    len_err = (r < 10) && (lim < 32'hFFFF);
    if (len_err) begin
      plen = lim + 1 + $urandom_range(0, 300);
      if (plen > 32'hFFFF) plen = 32'hFFFF;
    end else begin
      plen = $urandom_range(0, 24);
      if (plen > lim) plen = lim;
    end
    len = plen[15:0];
    put_beat(ACT_DATA, SYNC_UBX1);
    // broken second sync char
    if (r >= 10 && r < 18) begin
      bad = 8'($urandom);
      if (bad == SYNC_UBX2) bad = 8'h00;
      put_beat(ACT_DATA, bad);
      return;
    end
    put_beat(ACT_DATA, SYNC_UBX2);
    sum_a = '0;
    sum_b = '0;
    put_summed(8'($urandom), sum_a, sum_b);
    put_summed(8'($urandom), sum_a, sum_b);
    put_summed(len[7:0], sum_a, sum_b);
    put_summed(len[15:8], sum_a, sum_b);
    if (len_err) return;
    cut = (r >= 18 && r < 25) ? $urandom_range(0, plen) : plen + 1;
    for (int unsigned i = 0; i < plen; i++) begin
      if (i == cut) begin
        put_flush();
        return;
      end
      put_summed(8'($urandom), sum_a, sum_b);
    end
    if (cut == plen) begin
      put_flush();
      return;
    end
    if (r >= 25 && r < 35) begin
      if ($urandom_range(0, 1) != 0) sum_a = sum_a ^ 8'h5A;
      else sum_b = sum_b + 8'd1;
    end
    put_beat(ACT_DATA, sum_a);
    put_beat(ACT_DATA, sum_b);
  endtask

  task automatic queue_rtcm();
    logic [9:0]  len;
    logic [5:0]  rsv;
    int unsigned plen;
    int unsigned r;
    r = $urandom_range(0, 99);
    plen = (r < 95) ? $urandom_range(0, 24) : $urandom_range(100, 300);
    len = plen[9:0];
    rsv = 6'($urandom);
    put_beat(ACT_DATA, SYNC_RTCM);
    put_beat(ACT_DATA, {rsv, len[9:8]});
    put_beat(ACT_DATA, len[7:0]);
    for (int unsigned i = 0; i < plen; i++) begin
      if (r >= 88 && r < 95 && i == plen / 2) begin
        put_flush();
        return;
      end
      put_beat(ACT_DATA, 8'($urandom));
    end
    repeat (3) put_beat(ACT_DATA, 8'($urandom));
  endtask

  // waits until every queued beat went in and every result came back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (n_sent != n_queued || verdicts_due.size() != 0);
    repeat (2) @(posedge clk_i);
  endtask

  // one register write; caller lowers valid after the last one
  task automatic reg_write(input logic [gmpd_pkg::CfgIdxW-1:0] idx,
                           input logic [gmpd_pkg::CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    case (idx)
      gmpd_pkg::CFG_IDX_MAX_UBX:  lim_ubx_frame = val[gmpd_pkg::UbxMaxW-1:0];
      gmpd_pkg::CFG_IDX_MAX_NMEA: lim_nmea = val[gmpd_pkg::NmeaMaxW-1:0];
      gmpd_pkg::CFG_IDX_MAX_UNID: lim_unid = val[gmpd_pkg::UnidMaxW-1:0];
      default: ;
    endcase
  endtask

  // main sequence
  initial begin : sequencer
    int unsigned ubx_set [1:6];
    int unsigned nmea_set[1:6];
    int unsigned unid_set[1:6];
    int unsigned mark;
    int unsigned r;
    ubx_set  = '{8, 65543, 30, 0, 0, 2048};
    nmea_set = '{2, 1024, 12, 0, 0, 256};
    unid_set = '{1, 65535, 5, 0, 0, 256};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at reset settings, no idling
    src_idle_en = SRC_IDLE_MASK[0];
    snk_idle_en = SNK_IDLE_MASK[0];
    put_flush();
    put_beat(ACT_DATA, 8'h00);
    put_beat(ACT_DATA, 8'hFF);
    put_beat(ACT_DATA, CH_DOLLAR);
    put_beat(ACT_DATA, 8'h41);
    put_beat(ACT_DATA, CH_CR);
    put_beat(ACT_DATA, CH_LF);
    // bad second sync char that would otherwise start a sentence
    put_beat(ACT_DATA, SYNC_UBX1);
    put_beat(ACT_DATA, CH_DOLLAR);
    // ubx frame with empty payload
    put_beat(ACT_DATA, SYNC_UBX1);
    put_beat(ACT_DATA, SYNC_UBX2);
    put_beat(ACT_DATA, 8'h01);
    put_beat(ACT_DATA, 8'h02);
    put_beat(ACT_DATA, 8'h00);
    put_beat(ACT_DATA, 8'h00);
    put_beat(ACT_DATA, 8'h03);
    put_beat(ACT_DATA, 8'h0A);
    // rtcm frame with empty payload
    put_beat(ACT_DATA, SYNC_RTCM);
    put_beat(ACT_DATA, 8'h00);
    put_beat(ACT_DATA, 8'h00);
    put_beat(ACT_DATA, 8'h11);
    put_beat(ACT_DATA, 8'h22);
    put_beat(ACT_DATA, 8'h33);
    // sentence without LF, then a flush mid-frame
    put_beat(ACT_DATA, CH_DOLLAR);
    put_beat(ACT_DATA, CH_CR);
    put_beat(ACT_DATA, 8'h00);
    put_beat(ACT_DATA, SYNC_RTCM);
    put_flush();
    wait_idle();

    // random phases over several register settings
    for (int p = 1; p <= 6; p++) begin
      if (p == 5) begin
        ubx_set[5]  = $urandom_range(8, 80);
        nmea_set[5] = $urandom_range(2, 40);
        unid_set[5] = $urandom_range(1, 24);
      end
      reg_write(gmpd_pkg::CFG_IDX_MAX_UBX, 17'(ubx_set[p]));
      reg_write(gmpd_pkg::CFG_IDX_MAX_NMEA, 17'(nmea_set[p]));
      reg_write(gmpd_pkg::CFG_IDX_MAX_UNID, 17'(unid_set[p]));
      if (p == 1) reg_write(CFG_IDX_UNUSED, 17'h1FFFF);
      cfg_valid_i <= 1'b0;
      n_settings++;
      src_idle_en = SRC_IDLE_MASK[p];
      snk_idle_en = SNK_IDLE_MASK[p];
      // receiver holds off while the sender keeps offering beats
      if (p == 2) holds_asked++;
      mark = n_queued;
      while (n_queued - mark < PHASE_BEATS) begin
        r = $urandom_range(0, 99);
        if (r < 25) queue_nmea();
        else if (r < 50) queue_ubx();
        else if (r < 68) queue_rtcm();
        else if (r < 90) queue_noise();
        else put_flush();
      end
      wait_idle();
    end

    repeat (4) @(posedge clk_i);
    $display("covered %0d input beats (%0d flushes) under the reset and %0d written settings",
             n_sent, n_flushes, n_settings);
    $display("verdicts seen: %0d frames closed, %0d frame errors, %0d chunk ends",
             n_frames_ok, n_frame_errs, n_chunks);
    if (n_fail == 0) begin
      $display("** gnss_multi_protocol_deframer: PASSED **");
    end else begin
      $display("** gnss_multi_protocol_deframer: FAILED **");
    end
    $finish;
  end

endmodule
